// ===== rtl/mbfps_pkg.sv =====
package mbfps_pkg;

	localparam int MAX_BALLS = 16;
	localparam int BALL_AW   = $clog2(MAX_BALLS);
	localparam int CNT_W     = $clog2(MAX_BALLS + 1);
	localparam int FIELD_W   = 20;
	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;
	localparam int NUM_W     = 32;

	localparam logic [1:0] FUNC_PIXEL = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_LOAD  = 2'd2;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 20;
	localparam logic [CFG_AW-1:0] REG_ACTIVE = 3'd0;
	localparam logic [CFG_AW-1:0] REG_WIDTH  = 3'd1;
	localparam logic [CFG_AW-1:0] REG_HEIGHT = 3'd2;
	localparam logic [CFG_AW-1:0] REG_HIGH   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_MID    = 3'd4;
	localparam logic [CFG_AW-1:0] REG_LOW    = 3'd5;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [7:0]  vx;
		logic signed [7:0]  vy;
		logic [7:0]         r;
	} ball_t;

	localparam int BALL_W = $bits(ball_t);

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [FIELD_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== rtl/metaball_field_pixel_shader.sv =====
// Pixel request: each active ball passes the read, square, sum and compare states, and a ball
// whose term is not zero or capped also waits in the divide state; the finish state ends it.
// Tick request: each active ball is read, then written back through the one table RAM.
// Load request: written on acceptance. One request is worked on at a time; the result register frees input.
// Reset: control and configuration registers take their reset values; table entries read as zero until loaded,
// tracked by one valid bit per entry, so no clearing pass is needed.
module metaball_field_pixel_shader (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// pixel_x, pixel_y, ball_slot, load_pos_x, load_pos_y, load_vel_x, load_vel_y, load_radius
	input  logic [79:0]               s_tdata,
	// func
	input  logic [1:0]                s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// color_class, field_sum, zero fill
	output logic [23:0]               m_tdata,
	input  logic                      cfg_we,
	input  logic [mbfps_pkg::CFG_AW-1:0] cfg_index,
	input  logic [mbfps_pkg::CFG_DW-1:0] cfg_data
);
	import mbfps_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_TK   = 3'd2;
	localparam logic [2:0] ST_SQ   = 3'd3;
	localparam logic [2:0] ST_D2   = 3'd4;
	localparam logic [2:0] ST_CMP  = 3'd5;
	localparam logic [2:0] ST_DV   = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]          state_q;
	logic [4:0]          active_q;
	logic [9:0]          width_q;
	logic [9:0]          height_q;
	logic [19:0]         high_q;
	logic [19:0]         mid_q;
	logic [19:0]         low_q;
	logic [MAX_BALLS-1:0] valid_q;
	logic [BALL_AW-1:0]  idx_q;
	logic [BALL_AW-1:0]  last_q;
	logic                tick_q;
	logic [9:0]          px_q;
	logic [9:0]          py_q;
	logic [FIELD_W-1:0]  sum_q;
	logic                vld_s1;
	logic [31:0]         dx2_s2;
	logic [31:0]         dy2_s2;
	logic [15:0]         rr_s2;
	logic [31:0]         d2_s3;
	logic [15:0]         rr_s3;
	logic                m_valid_q;
	logic [1:0]          cls_q;
	logic [FIELD_W-1:0]  out_sum_q;

	logic                acc;
	logic [1:0]          func;
	logic [CNT_W-1:0]    n_eff;
	logic                ram_we;
	logic [BALL_AW-1:0]  ram_waddr;
	ball_t               ram_wdata;
	ball_t               ram_rdata;
	ball_t               cur;
	ball_t               load_b;
	ball_t               tick_b;
	logic signed [16:0]  dx;
	logic signed [16:0]  dy;
	logic signed [15:0]  nx;
	logic signed [15:0]  ny;
	logic [51:0]         d2_sh;
	logic [31:0]         num;
	logic                term_go;
	logic [FIELD_W-1:0]  term;
	logic [FIELD_W:0]    sum_add;
	logic [1:0]          cls;
	logic                out_free;
	div_req_t            dreq;
	div_rsp_t            drsp;

	assign func     = s_tuser;
	assign s_tready = state_q == ST_IDLE;
	assign acc      = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign n_eff    = (active_q > 5'(MAX_BALLS)) ? CNT_W'(MAX_BALLS) : CNT_W'(active_q);

	assign load_b.x  = s_tdata[39:24];
	assign load_b.y  = s_tdata[55:40];
	assign load_b.vx = s_tdata[63:56];
	assign load_b.vy = s_tdata[71:64];
	assign load_b.r  = s_tdata[79:72];

	assign cur = vld_s1 ? ram_rdata : '0;

	assign nx = cur.x + 16'(cur.vx);
	assign ny = cur.y + 16'(cur.vy);
	always_comb begin
		tick_b   = cur;
		tick_b.x = nx;
		tick_b.y = ny;
		if (nx < 0 || 17'(nx) > $signed({7'b0, width_q})) begin
			tick_b.vx = 8'(-cur.vx);
		end
		if (ny < 0 || 17'(ny) > $signed({7'b0, height_q})) begin
			tick_b.vy = 8'(-cur.vy);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = tick_b;
		if (acc && func == FUNC_LOAD) begin
			ram_we    = 1'b1;
			ram_waddr = s_tdata[23:20];
			ram_wdata = load_b;
		end else if (state_q == ST_TK) begin
			ram_we = 1'b1;
		end
	end

	mbfps_ram #(
		.WIDTH(BALL_W),
		.DEPTH(MAX_BALLS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign dx    = $signed({7'b0, px_q}) - 17'(cur.x);
	assign dy    = $signed({7'b0, py_q}) - 17'(cur.y);
	assign num   = {rr_s3, 16'b0};
	assign d2_sh = {d2_s3, 20'b0};

	always_comb begin
		term_go = 1'b0;
		term    = '0;
		if (rr_s3 == '0) begin
			term = '0;
		end else if (d2_s3 == '0 || 52'(num) >= d2_sh) begin
			term = FIELD_MAX;
		end else begin
			term_go = 1'b1;
		end
		if (state_q == ST_DV) begin
			term = drsp.quo;
		end
	end

	assign dreq.start = state_q == ST_CMP && term_go;
	assign dreq.num   = num;
	assign dreq.den   = d2_s3;

	mbfps_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);

	assign sum_add = {1'b0, sum_q} + {1'b0, term};

	always_comb begin
		if (sum_q > high_q) begin
			cls = 2'd3;
		end else if (sum_q > mid_q) begin
			cls = 2'd2;
		end else if (sum_q > low_q) begin
			cls = 2'd1;
		end else begin
			cls = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= 5'd2;
			width_q   <= 10'd320;
			height_q  <= 10'd240;
			high_q    <= 20'd42598;
			mid_q     <= 20'd32768;
			low_q     <= 20'd26214;
			valid_q   <= '0;
			m_valid_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ACTIVE: active_q <= cfg_data[4:0];
					REG_WIDTH:  width_q  <= cfg_data[9:0];
					REG_HEIGHT: height_q <= cfg_data[9:0];
					REG_HIGH:   high_q   <= cfg_data;
					REG_MID:    mid_q    <= cfg_data;
					REG_LOW:    low_q    <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_FIN && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q) inside
				ST_IDLE: begin
					idx_q <= '0;
					if (acc && (func == FUNC_PIXEL || func == FUNC_TICK)) begin
						state_q <= (n_eff == '0) ? ((func == FUNC_PIXEL) ? ST_FIN : ST_IDLE)
							: ST_RD;
					end
				end
				ST_RD:  state_q <= tick_q ? ST_TK : ST_SQ;
				ST_TK: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q == last_q) ? ST_IDLE : ST_RD;
				end
				ST_SQ:  state_q <= ST_D2;
				ST_D2:  state_q <= ST_CMP;
				ST_CMP, ST_DV: begin
					if (state_q == ST_CMP && term_go) begin
						state_q <= ST_DV;
					end else if (state_q == ST_CMP || drsp.done) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= (idx_q == last_q) ? ST_FIN : ST_RD;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		vld_s1 <= valid_q[idx_q];
		if (acc) begin
			tick_q <= func == FUNC_TICK;
			px_q   <= s_tdata[9:0];
			py_q   <= s_tdata[19:10];
			last_q <= BALL_AW'(n_eff - 1'b1);
			sum_q  <= '0;
		end
		if (state_q == ST_SQ) begin
			dx2_s2 <= 32'(dx * dx);
			dy2_s2 <= 32'(dy * dy);
			rr_s2  <= cur.r * cur.r;
		end
		if (state_q == ST_D2) begin
			d2_s3 <= dx2_s2 + dy2_s2;
			rr_s3 <= rr_s2;
		end
		if ((state_q == ST_CMP && !term_go) || (state_q == ST_DV && drsp.done)) begin
			sum_q <= sum_add[FIELD_W] ? FIELD_MAX : sum_add[FIELD_W-1:0];
		end
		if (state_q == ST_FIN && out_free) begin
			cls_q     <= cls;
			out_sum_q <= sum_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b0, out_sum_q, cls_q};

endmodule

// ===== rtl/mbfps_ram.sv =====
module mbfps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/mbfps_div.sv =====
module mbfps_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mbfps_pkg::div_req_t req,
	output mbfps_pkg::div_rsp_t rsp
);
	import mbfps_pkg::*;

	localparam int STEP_W = $clog2(FIELD_W + 1);

	logic [NUM_W-1:0]   rem_q;
	logic [NUM_W-1:0]   den_q;
	logic [FIELD_W-1:0] low_q;
	logic [FIELD_W-1:0] quo_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               done_q;
	logic [NUM_W:0]     trial;
	logic               fits;

	assign trial = {rem_q, low_q[FIELD_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= STEP_W'(FIELD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= NUM_W'(req.num[NUM_W-1:FIELD_W]);
			low_q <= req.num[FIELD_W-1:0];
			den_q <= req.den;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? NUM_W'(trial - {1'b0, den_q}) : NUM_W'(trial);
			low_q <= {low_q[FIELD_W-2:0], 1'b0};
			quo_q <= {quo_q[FIELD_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule
